[rtl/sjf_pkg.sv]
// Shared types, constants and helpers for the shortest-job-first scheduler.
package sjf_pkg;

  localparam int ARR_W    = 16;
  localparam int BURST_W  = 16;
  localparam int TIME_W   = 21;
  localparam int JOB_ID_W = 5;

  localparam logic [TIME_W-1:0] TIME_MAX = TIME_W'(1114095);

  typedef struct packed {
    logic [ARR_W-1:0]   arrival_time;
    logic [BURST_W-1:0] burst_time;
    logic               last_job;
  } job_t;

  typedef struct packed {
    logic [JOB_ID_W-1:0] job_id;
    logic [TIME_W-1:0]   waiting_time;
    logic [TIME_W-1:0]   turnaround_time;
    logic                last_result;
  } result_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DECIDE,
    ST_EMIT
  } state_t;

  // commands broadcast to every cell
  typedef struct packed {
    logic load_en;
    logic finish_en;
    logic shift_en;
  } cell_cmd_t;

  // search transaction handed from cell to cell
  typedef struct packed {
    logic               found;
    logic [BURST_W-1:0] best_burst;
    logic               pending;
    logic [ARR_W-1:0]   next_arrival;
  } scan_t;

  function automatic logic [TIME_W-1:0] sat_time(input logic [TIME_W:0] s);
    logic [TIME_W-1:0] r;
    if (s > {1'b0, TIME_MAX}) begin
      r = TIME_MAX;
    end else begin
      r = s[TIME_W-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/sjf_stream_if.sv]
// Valid/ready stream channel carrying one payload transaction.
interface sjf_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/sjf_cell.sv]
// One job slot: holds a job, joins the search chain and the result shift chain.
module sjf_cell
  import sjf_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int IDX_W = 4,
  parameter int CNT_W = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cell_cmd_t             cmd,
  input  logic [CNT_W-1:0]      job_count,
  input  logic [IDX_W-1:0]      pick,
  input  job_t                  job,
  input  logic [TIME_W-1:0]     clock_now,
  input  scan_t                 scan_in,
  input  logic [IDX_W-1:0]      pick_in,
  output scan_t                 scan_out,
  output logic [IDX_W-1:0]      pick_out,
  input  logic [TIME_W-1:0]     wait_in,
  input  logic [BURST_W-1:0]    burst_in,
  output logic [TIME_W-1:0]     wait_out,
  output logic [BURST_W-1:0]    burst_out
);

  logic [ARR_W-1:0]   arrival;
  logic [BURST_W-1:0] burst;
  logic [TIME_W-1:0]  wait_val;
  logic               finished;

  logic               active;
  logic               is_ready;
  logic               is_pending;
  scan_t              scan_next;
  logic [IDX_W-1:0]   pick_next;

  assign active     = CNT_W'(INDEX) < job_count;
  assign is_ready   = active && !finished && ({{(TIME_W-ARR_W){1'b0}}, arrival} <= clock_now);
  assign is_pending = active && !finished && !is_ready;

  always_comb begin
    scan_next = scan_in;
    pick_next = pick_in;
    if (is_ready && (!scan_in.found || burst < scan_in.best_burst)) begin
      scan_next.found      = 1'b1;
      scan_next.best_burst = burst;
      pick_next            = IDX_W'(INDEX);
    end
    if (is_pending && (!scan_in.pending || arrival < scan_in.next_arrival)) begin
      scan_next.pending      = 1'b1;
      scan_next.next_arrival = arrival;
    end
  end

  always_ff @(posedge clk) begin
    scan_out <= scan_next;
    pick_out <= pick_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      finished <= 1'b0;
    end else if (cmd.load_en && job_count == CNT_W'(INDEX)) begin
      finished <= 1'b0;
    end else if (cmd.finish_en && pick == IDX_W'(INDEX)) begin
      finished <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_en && job_count == CNT_W'(INDEX)) begin
      arrival <= job.arrival_time;
      burst   <= job.burst_time;
    end else if (cmd.shift_en) begin
      burst   <= burst_in;
    end
    if (cmd.finish_en && pick == IDX_W'(INDEX)) begin
      wait_val <= clock_now - {{(TIME_W-ARR_W){1'b0}}, arrival};
    end else if (cmd.shift_en) begin
      wait_val <= wait_in;
    end
  end

  assign wait_out  = wait_val;
  assign burst_out = burst;

endmodule

[rtl/sjf_nonpreemptive_schedule_core.sv]
// Non-preemptive shortest-job-first scheduler: a chain of job cells and its sequencer.
// Loading accepts a job whenever one is offered; the item marked last starts scheduling.
// Each decision is one pass of a search transaction down the cell chain.
// A set of N jobs needs N picks plus at most N idle jumps.
// Results then leave one per cycle while result is ready, in load order, as the cell chain shifts.
// Synchronous active-high reset empties the job set and returns to loading.
module sjf_nonpreemptive_schedule_core
  import sjf_pkg::*;
#(
  parameter int MAX_JOBS = 16
) (
  input  logic        clk,
  input  logic        rst,
  sjf_stream_if.sink   job,
  sjf_stream_if.source result
);

  localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W = $clog2(MAX_JOBS + 1);

  state_t            state;
  state_t            state_next;
  logic [CNT_W-1:0]  job_count;
  logic [CNT_W-1:0]  job_count_next;
  logic [CNT_W-1:0]  done_count;
  logic [CNT_W-1:0]  done_count_next;
  logic [TIME_W-1:0] sched_clock;
  logic [TIME_W-1:0] sched_clock_next;
  logic [IDX_W-1:0]  scan_cnt;
  logic [IDX_W-1:0]  scan_cnt_next;
  logic [CNT_W-1:0]  emit_idx;
  logic [CNT_W-1:0]  emit_idx_next;

  cell_cmd_t         cmd;
  scan_t             scan_chain  [MAX_JOBS];
  logic [IDX_W-1:0]  pick_chain  [MAX_JOBS];
  logic [TIME_W-1:0] wait_chain  [MAX_JOBS];
  logic [BURST_W-1:0] burst_chain [MAX_JOBS];
  scan_t             scan_head;
  scan_t             tail;
  logic [IDX_W-1:0]  tail_pick;

  logic              in_fire;
  logic              out_fire;
  logic [CNT_W:0]    emit_num;
  logic              emit_last;
  logic [TIME_W:0]   clock_sum;
  logic [TIME_W:0]   tat_sum;

  assign scan_head = '{found: 1'b0, best_burst: '0, pending: 1'b0, next_arrival: '0};
  assign tail      = scan_chain[MAX_JOBS-1];
  assign tail_pick = pick_chain[MAX_JOBS-1];

  for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
    scan_t              s_in;
    logic [IDX_W-1:0]   p_in;
    logic [TIME_W-1:0]  w_in;
    logic [BURST_W-1:0] b_in;

    if (i == 0) begin : g_head
      assign s_in = scan_head;
      assign p_in = '0;
    end else begin : g_link
      assign s_in = scan_chain[i-1];
      assign p_in = pick_chain[i-1];
    end

    if (i == MAX_JOBS - 1) begin : g_end
      assign w_in = wait_chain[i];
      assign b_in = burst_chain[i];
    end else begin : g_mid
      assign w_in = wait_chain[i+1];
      assign b_in = burst_chain[i+1];
    end

    sjf_cell #(
      .INDEX(i),
      .IDX_W(IDX_W),
      .CNT_W(CNT_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .job_count(job_count),
      .pick     (tail_pick),
      .job      (job.data),
      .clock_now(sched_clock),
      .scan_in  (s_in),
      .pick_in  (p_in),
      .scan_out (scan_chain[i]),
      .pick_out (pick_chain[i]),
      .wait_in  (w_in),
      .burst_in (b_in),
      .wait_out (wait_chain[i]),
      .burst_out(burst_chain[i])
    );
  end

  assign job.ready    = (state == ST_LOAD);
  assign result.valid = (state == ST_EMIT);
  assign in_fire      = job.valid && job.ready;
  assign out_fire     = result.valid && result.ready;

  assign emit_num  = {1'b0, emit_idx} + (CNT_W+1)'(1);
  assign emit_last = (emit_num == {1'b0, job_count});
  assign clock_sum = {1'b0, sched_clock} + (TIME_W+1)'(tail.best_burst);
  assign tat_sum   = {1'b0, wait_chain[0]} + (TIME_W+1)'(burst_chain[0]);

  assign result.data.job_id          = JOB_ID_W'(emit_num);
  assign result.data.waiting_time    = wait_chain[0];
  assign result.data.turnaround_time = sat_time(tat_sum);
  assign result.data.last_result     = emit_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_LOAD;
      job_count   <= '0;
      done_count  <= '0;
      sched_clock <= '0;
      scan_cnt    <= '0;
      emit_idx    <= '0;
    end else begin
      state       <= state_next;
      job_count   <= job_count_next;
      done_count  <= done_count_next;
      sched_clock <= sched_clock_next;
      scan_cnt    <= scan_cnt_next;
      emit_idx    <= emit_idx_next;
    end
  end

  always_comb begin
    state_next       = state;
    job_count_next   = job_count;
    done_count_next  = done_count;
    sched_clock_next = sched_clock;
    scan_cnt_next    = scan_cnt;
    emit_idx_next    = emit_idx;
    cmd              = '0;
    case (state)
      ST_LOAD: begin
        if (in_fire) begin
          if (job_count < CNT_W'(MAX_JOBS)) begin
            cmd.load_en    = 1'b1;
            job_count_next = job_count + CNT_W'(1);
          end
          if (job.data.last_job) begin
            state_next       = ST_SCAN;
            scan_cnt_next    = '0;
            done_count_next  = '0;
            sched_clock_next = '0;
          end
        end
      end
      ST_SCAN: begin
        scan_cnt_next = scan_cnt + IDX_W'(1);
        if (scan_cnt == IDX_W'(MAX_JOBS - 1)) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        scan_cnt_next = '0;
        if (tail.found) begin
          cmd.finish_en    = 1'b1;
          sched_clock_next = sat_time(clock_sum);
          done_count_next  = done_count + CNT_W'(1);
          if (done_count + CNT_W'(1) == job_count) begin
            state_next    = ST_EMIT;
            emit_idx_next = '0;
          end else begin
            state_next = ST_SCAN;
          end
        end else if (tail.pending) begin
          sched_clock_next = {{(TIME_W-ARR_W){1'b0}}, tail.next_arrival};
          state_next       = ST_SCAN;
        end else begin
          state_next    = ST_EMIT;
          emit_idx_next = '0;
        end
      end
      ST_EMIT: begin
        if (out_fire) begin
          cmd.shift_en  = 1'b1;
          emit_idx_next = emit_num[CNT_W-1:0];
          if (emit_last) begin
            state_next       = ST_LOAD;
            job_count_next   = '0;
            sched_clock_next = '0;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(job.ready && result.valid))
    else $error("input and output open at the same time");

  a_pick_counts: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DECIDE && tail.found) |=> done_count == CNT_W'($past(done_count) + 1'b1))
    else $error("pick did not advance done count");

  a_clock_range: assert property (@(posedge clk) disable iff (rst)
    sched_clock <= TIME_MAX)
    else $error("scheduler clock beyond range");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    job_count <= CNT_W'(MAX_JOBS))
    else $error("job count beyond capacity");

  a_emit_complete: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (done_count == job_count))
    else $error("emitting before all jobs scheduled");

endmodule
